[hdl/mono_bitmap_blit_2x_top_assert.svh]
// Assertion macros for the doubled-scale sprite row blitter.
// Used by mono_bitmap_blit_2x_top; expects clk_i and rst_ni in scope.
`ifndef MONO_BITMAP_BLIT_2X_TOP_ASSERT_SVH
`define MONO_BITMAP_BLIT_2X_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MBB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mbb assertion failed");
`define MBB_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mbb forbidden condition seen");
`else
`define MBB_ASSERT(lbl, prop)
`define MBB_NEVER(lbl, expr)
`endif
`endif

[hdl/mbb_pkg.sv]
// Shared types and constants for the doubled-scale sprite row blitter.
// No dependencies; used by mbb_ctrl, mbb_datapath and the top level.
`timescale 1ns / 1ps

package mbb_pkg;

  localparam int AddrW = 20;
  localparam int ColorW = 32;
  localparam int LineW = 13;
  localparam logic [LineW-1:0] LineWidthRst = 13'd640;

  // Configuration register indices
  localparam logic CfgBgColor = 1'b0;
  localparam logic CfgLineWidth = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input request
    logic prep;   // align row bits, form the line base address
    logic skip;   // advance past a column that draws nothing
    logic emit;   // push one result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pending;  // drawn columns remain
    logic drawn;    // current column draws
    logic last;     // current result is the row's final one
    logic out_free; // output register can take a result
  } status_t;

endpackage

[hdl/mbb_ctrl.sv]
// Controller state machine for the sprite row blitter.
// Depends on mbb_pkg; drives mbb_datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps

module mbb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mbb_pkg::status_t status_i,
  output mbb_pkg::cmd_t    cmd_o
);

  mbb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mbb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mbb_pkg::ST_LOAD;
      end
      mbb_pkg::ST_LOAD: begin
        state_d = mbb_pkg::ST_SCAN;
      end
      mbb_pkg::ST_SCAN: begin
        if (!status_i.pending) state_d = mbb_pkg::ST_IDLE;
      end
      default: state_d = mbb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      mbb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mbb_pkg::ST_LOAD: begin
        cmd_o.prep = 1'b1;
      end
      mbb_pkg::ST_SCAN: begin
        cmd_o.skip = status_i.pending && !status_i.drawn;
        cmd_o.emit = status_i.pending && status_i.drawn && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[hdl/mbb_datapath.sv]
// Datapath for the sprite row blitter: config registers, row shifters,
// address arithmetic and the output register. Depends on mbb_pkg.
`timescale 1ns / 1ps

module mbb_datapath #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic [31:0]                 shape_row_bits_i,
  input  logic [5:0]                  shape_width_i,
  input  logic [7:0]                  bitmap_row_i,
  input  logic [8:0]                  origin_col_i,
  input  logic [7:0]                  origin_row_i,
  input  logic [31:0]                 shape_color_i,
  input  logic                        erase_foreground_i,
  input  logic                        erase_background_i,
  input  mbb_pkg::cmd_t               cmd_i,
  output mbb_pkg::status_t            status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [mbb_pkg::AddrW-1:0]   pixel_address_o,
  output logic [mbb_pkg::ColorW-1:0]  pixel_color_o,
  output logic                        last_write_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [mbb_pkg::ColorW-1:0] bg_q;
  logic [mbb_pkg::LineW-1:0]  lw_q;

  logic [MAX_WIDTH-1:0]       bits_q, drawn_q, drawn_in;
  logic [CW-1:0]              shift_q, width_clamp;
  logic [9:0]                 line0_q;
  logic [mbb_pkg::AddrW-1:0]  xcol_q, base_q, addr;
  logic [mbb_pkg::ColorW-1:0] color_q, pix_color;
  logic                       efg_q, lower_q;
  logic [22:0]                prod;
  logic                       out_valid_q, last_q, out_free, advance, last_res;
  logic [mbb_pkg::AddrW-1:0]  addr_q;
  logic [mbb_pkg::ColorW-1:0] pcolor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= '0;
      lw_q <= mbb_pkg::LineWidthRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == mbb_pkg::CfgBgColor) bg_q <= cfg_data_i;
      if (cfg_index_i == mbb_pkg::CfgLineWidth) lw_q <= cfg_data_i[mbb_pkg::LineW-1:0];
    end
  end

  // Clamp width and mark the columns that draw
  always_comb begin
    width_clamp = ({1'b0, shape_width_i} > 7'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                          : CW'(shape_width_i);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      drawn_in[i] = (CW'(i) < width_clamp) && (shape_row_bits_i[i] || erase_background_i);
    end
  end

  assign prod     = 23'(line0_q) * 23'(lw_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = cmd_i.skip || (cmd_i.emit && lower_q);
  assign last_res = lower_q && ((drawn_q << 1) == '0);

  assign addr = base_q + xcol_q + (lower_q ? mbb_pkg::AddrW'(lw_q) : '0);
  assign pix_color = (bits_q[MAX_WIDTH-1] && !efg_q) ? color_q : bg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bits_q  <= shape_row_bits_i[MAX_WIDTH-1:0];
      drawn_q <= drawn_in;
      shift_q <= CW'(MAX_WIDTH) - width_clamp;
      line0_q <= {(9'(origin_row_i) + 9'(bitmap_row_i)), 1'b0};
      xcol_q  <= mbb_pkg::AddrW'({origin_col_i, 1'b0});
      color_q <= shape_color_i;
      efg_q   <= erase_foreground_i;
    end else if (cmd_i.prep) begin
      // Put the leftmost pixel at the top bit
      bits_q  <= bits_q << shift_q;
      drawn_q <= drawn_q << shift_q;
      base_q  <= prod[mbb_pkg::AddrW-1:0];
    end else if (advance) begin
      bits_q  <= bits_q << 1;
      drawn_q <= drawn_q << 1;
      xcol_q  <= xcol_q + mbb_pkg::AddrW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) lower_q <= 1'b0;
      else if (cmd_i.emit) lower_q <= !lower_q;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      addr_q   <= addr;
      pcolor_q <= pix_color;
      last_q   <= last_res;
    end
  end

  assign status_o.pending  = |drawn_q;
  assign status_o.drawn    = drawn_q[MAX_WIDTH-1];
  assign status_o.last     = last_res;
  assign status_o.out_free = out_free;

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign pixel_color_o   = pcolor_q;
  assign last_write_o    = last_q;

endmodule

[hdl/mono_bitmap_blit_2x_top.sv]
// Channel      Direction  Handshake                Payload
// cfg          in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// row request  in         in_valid_i/in_ready_o    shape fields, origin, colour, flags
// pixel write  out        out_valid_o/out_ready_i  pixel_address_o, pixel_color_o, last_write_o
//
// A row request is captured, then a setup step aligns the row bits and forms the line
// base address, then the scan handles one skipped column or one result a cycle.
// Reset (asynchronous, active low) sets background colour to 0 and line width to
// 640. A stalled output holds the scan; a new request is taken once the scan has
// found no drawn columns left and the controller has returned to idle.
//
// Top level of the doubled-scale sprite row blitter.
// Depends on mbb_pkg, mbb_ctrl, mbb_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "mono_bitmap_blit_2x_top_assert.svh"

module mono_bitmap_blit_2x_top #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // row request
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] shape_row_bits_i,
  input  logic [5:0]  shape_width_i,
  input  logic [7:0]  bitmap_row_i,
  input  logic [8:0]  origin_col_i,
  input  logic [7:0]  origin_row_i,
  input  logic [31:0] shape_color_i,
  input  logic        erase_foreground_i,
  input  logic        erase_background_i,
  // pixel pair writes
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [19:0] pixel_address_o,
  output logic [31:0] pixel_color_o,
  output logic        last_write_o
);

  mbb_pkg::cmd_t    cmd;
  mbb_pkg::status_t status;

  // Config registers are plain flops: always take the write
  assign cfg_ready_o = 1'b1;

  mbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbb_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .shape_row_bits_i   (shape_row_bits_i),
    .shape_width_i      (shape_width_i),
    .bitmap_row_i       (bitmap_row_i),
    .origin_col_i       (origin_col_i),
    .origin_row_i       (origin_row_i),
    .shape_color_i      (shape_color_i),
    .erase_foreground_i (erase_foreground_i),
    .erase_background_i (erase_background_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .pixel_address_o    (pixel_address_o),
    .pixel_color_o      (pixel_color_o),
    .last_write_o       (last_write_o)
  );

  // Never overwrite a result that is still waiting
  `MBB_NEVER(a_no_overwrite, cmd.emit && out_valid_o && !out_ready_i)
  // An accepted request is held off the input for the setup cycle
  `MBB_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // Queuing the final result frees the input once the controller is back in idle
  `MBB_ASSERT(a_idle_after_last, (cmd.emit && status.last) |=> ##1 in_ready_o)
  // Skip and emit are exclusive
  `MBB_NEVER(a_skip_emit, cmd.skip && cmd.emit)

endmodule

[sim/mono_bitmap_blit_2x_top_tb.sv]
// Self-checking testbench for mono_bitmap_blit_2x_top, the doubled-scale sprite row blitter.
// Depends on mbb_pkg and the blitter RTL. Runs a directed table, then randomised phases
// under several register settings, with a local predictor of the pixel-pair writes.
`timescale 1ns / 1ps

module mono_bitmap_blit_2x_top_tb;

  localparam int MAX_WIDTH = 32;
  // Longest scan of one row with a free output, plus margin: covers rows that draw nothing
  localparam int SCAN_CYCLES = 2 * MAX_WIDTH + 3 + 13;
  localparam int ROWS_PER_PHASE = 70;
  localparam int N_PHASES = 7;
  localparam int LONG_HOLD = 400;

  // How a table row is checked: by the predictor, or by values typed in
  localparam int PREDICT = -1;
  localparam int NO_WRITES = 0;
  localparam int ONE_PIXEL = 2;

  typedef struct {
    logic [31:0] bits;
    logic [5:0]  width;
    logic [7:0]  sprite_row;
    logic [8:0]  org_col;
    logic [7:0]  org_row;
    logic [mbb_pkg::ColorW-1:0] colour;
    logic        erase_fg;
    logic        erase_bg;
    int          typed_n;
    logic [mbb_pkg::AddrW-1:0] typed_up;
    logic [mbb_pkg::AddrW-1:0] typed_lo;
    logic [mbb_pkg::ColorW-1:0] typed_colour;
  } row_req_t;

  typedef struct {
    logic [mbb_pkg::AddrW-1:0]  addr;
    logic [mbb_pkg::ColorW-1:0] colour;
    logic                       last;
  } pixel_wr_t;

  typedef struct {
    logic [mbb_pkg::ColorW-1:0] bg;
    logic [mbb_pkg::LineW-1:0]  line_words;
  } cfg_set_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] shape_row_bits_i = '0;
  logic [5:0]  shape_width_i = '0;
  logic [7:0]  bitmap_row_i = '0;
  logic [8:0]  origin_col_i = '0;
  logic [7:0]  origin_row_i = '0;
  logic [31:0] shape_color_i = '0;
  logic        erase_foreground_i = 1'b0;
  logic        erase_background_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [19:0] pixel_address_o;
  logic [31:0] pixel_color_o;
  logic        last_write_o;

  // Local copy of the two registers, as they stand after reset
  logic [mbb_pkg::ColorW-1:0] bg_colour_reg = '0;
  logic [mbb_pkg::LineW-1:0]  line_words_reg = mbb_pkg::LineWidthRst;

  pixel_wr_t pending_writes[$];
  int unsigned mismatch_cnt = 0;
  bit long_hold_req = 1'b0;

  // Directed rows, all sent under the reset register values (background 0, 640 words).
  // Typed rows draw one pixel or none, so their writes can be read off directly.
  row_req_t dir_tab [18] = '{
    // single set pixel at the origin
    '{32'h0000_0001, 6'd1,  8'd0,   9'd0,   8'd0,   32'hFFFF_FFFF, 1'b0, 1'b0,
      ONE_PIXEL, 20'd0, 20'd640, 32'hFFFF_FFFF},
    // zero width draws nothing, even with erase_background set
    '{32'hFFFF_FFFF, 6'd0,  8'd0,   9'd0,   8'd0,   32'h1111_1111, 1'b0, 1'b1,
      NO_WRITES, 20'd0, 20'd0, 32'h0},
    // empty full-width row
    '{32'h0000_0000, 6'd32, 8'd0,   9'd0,   8'd0,   32'h2222_2222, 1'b0, 1'b0,
      NO_WRITES, 20'd0, 20'd0, 32'h0},
    // leftmost pixel at the far corner of every origin field
    '{32'h8000_0000, 6'd32, 8'd255, 9'd511, 8'd255, 32'h1234_5678, 1'b0, 1'b0,
      ONE_PIXEL, 20'd653822, 20'd654462, 32'h1234_5678},
    // oversized width clamps: leftmost pixel is bit 31
    '{32'h8000_0000, 6'd63, 8'd0,   9'd0,   8'd0,   32'hC0FF_EE00, 1'b0, 1'b0,
      ONE_PIXEL, 20'd0, 20'd640, 32'hC0FF_EE00},
    // clamped width, bit 0 is column 31
    '{32'h0000_0001, 6'd40, 8'd0,   9'd0,   8'd0,   32'h0F0F_0F0F, 1'b0, 1'b0,
      ONE_PIXEL, 20'd62, 20'd702, 32'h0F0F_0F0F},
    // erase_foreground paints a set pixel in the background colour
    '{32'h0000_0001, 6'd1,  8'd0,   9'd0,   8'd0,   32'hAAAA_AAAA, 1'b1, 1'b0,
      ONE_PIXEL, 20'd0, 20'd640, 32'h0000_0000},
    // erase_background paints a clear pixel
    '{32'h0000_0000, 6'd1,  8'd0,   9'd0,   8'd0,   32'h5555_5555, 1'b0, 1'b1,
      ONE_PIXEL, 20'd0, 20'd640, 32'h0000_0000},
    // clear pixel skipped
    '{32'h0000_0000, 6'd1,  8'd0,   9'd0,   8'd0,   32'h5555_5555, 1'b0, 1'b0,
      NO_WRITES, 20'd0, 20'd0, 32'h0},
    // bits above the width are ignored
    '{32'hFFFF_FFFE, 6'd1,  8'd0,   9'd0,   8'd0,   32'h3333_3333, 1'b0, 1'b0,
      NO_WRITES, 20'd0, 20'd0, 32'h0},
    '{32'hFFFF_FFFF, 6'd32, 8'd3,   9'd17,  8'd9,   32'h5A5A_A5A5, 1'b0, 1'b0,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'h0000_0000, 6'd32, 8'd1,   9'd2,   8'd3,   32'h7777_7777, 1'b0, 1'b1,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'hAAAA_AAAA, 6'd32, 8'd0,   9'd100, 8'd50,  32'h1357_9BDF, 1'b1, 1'b1,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'h5555_5555, 6'd32, 8'd7,   9'd300, 8'd200, 32'h2468_ACE0, 1'b0, 1'b0,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'h0000_FFFF, 6'd16, 8'd0,   9'd319, 8'd239, 32'h8765_4321, 1'b0, 1'b1,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'h0000_0001, 6'd33, 8'd128, 9'd256, 8'd128, 32'h0000_0001, 1'b0, 1'b1,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'h8000_0001, 6'd63, 8'd255, 9'd511, 8'd255, 32'hFFFF_0000, 1'b1, 1'b1,
      PREDICT, 20'd0, 20'd0, 32'h0},
    '{32'h1234_5678, 6'd31, 8'd64,  9'd64,  8'd64,  32'h00FF_00FF, 1'b0, 1'b1,
      PREDICT, 20'd0, 20'd0, 32'h0}
  };

  // Register settings per random phase; the last phase draws its own
  cfg_set_t cfg_sets [N_PHASES-1] = '{
    '{32'hFFFF_FFFF, 13'd8191},
    '{32'h0000_0000, 13'd0},
    '{32'h5A5A_C3C3, 13'd1},
    '{32'h0000_0001, 13'd2},
    '{32'h8000_0000, 13'd4096},
    '{32'hA5A5_3C3C, 13'd320}
  };

  mono_bitmap_blit_2x_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .shape_row_bits_i,
    .shape_width_i,
    .bitmap_row_i,
    .origin_col_i,
    .origin_row_i,
    .shape_color_i,
    .erase_foreground_i,
    .erase_background_i,
    .out_valid_o,
    .out_ready_i,
    .pixel_address_o,
    .pixel_color_o,
    .last_write_o
  );

  always #1 clk_i = ~clk_i;

  // Work out the pixel-pair writes of one row request and queue them in order:
  // upper line then lower line per drawn pixel, last flag on the final write.
  task automatic blit_row(input row_req_t r);
    int unsigned span;
    int unsigned c;
    longint unsigned line0;
    longint unsigned xcol;
    logic [mbb_pkg::ColorW-1:0] word;
    bit drawn;
    bit held;
    pixel_wr_t lower;
    span = (r.width > MAX_WIDTH) ? MAX_WIDTH : r.width;
    line0 = 2 * (longint'(r.org_row) + longint'(r.sprite_row));
    held = 1'b0;
    lower = '{addr: '0, colour: '0, last: 1'b0};
    for (c = 0; c < span; c++) begin
      drawn = 1'b1;
      word = '0;
      if (r.bits[span - 1 - c]) begin
        word = r.erase_fg ? bg_colour_reg : r.colour;
      end else if (r.erase_bg) begin
        word = bg_colour_reg;
      end else begin
        drawn = 1'b0;
      end
      if (drawn) begin
        xcol = 2 * (longint'(r.org_col) + c);
        // hold back the lower write so the final one can take the last flag
        if (held) pending_writes.push_back(lower);
        pending_writes.push_back('{addr: mbb_pkg::AddrW'(line0 * line_words_reg + xcol),
                                   colour: word, last: 1'b0});
        lower = '{addr: mbb_pkg::AddrW'((line0 + 1) * line_words_reg + xcol),
                  colour: word, last: 1'b0};
        held = 1'b1;
      end
    end
    if (held) begin
      lower.last = 1'b1;
      pending_writes.push_back(lower);
    end
  endtask

  // Offer one row request and hold it until accepted; valid is left high for the caller.
  task automatic send_row(input row_req_t r);
    in_valid_i <= 1'b1;
    shape_row_bits_i <= r.bits;
    shape_width_i <= r.width;
    bitmap_row_i <= r.sprite_row;
    origin_col_i <= r.org_col;
    origin_row_i <= r.org_row;
    shape_color_i <= r.colour;
    erase_foreground_i <= r.erase_fg;
    erase_background_i <= r.erase_bg;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.typed_n == PREDICT) begin
      blit_row(r);
    end else if (r.typed_n == ONE_PIXEL) begin
      pending_writes.push_back('{addr: r.typed_up, colour: r.typed_colour, last: 1'b0});
      pending_writes.push_back('{addr: r.typed_lo, colour: r.typed_colour, last: 1'b1});
    end
  endtask

  // Write one register; valid stays high, the caller drops it after the last write.
  task automatic cfg_write(input logic idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mbb_pkg::CfgBgColor) bg_colour_reg = data;
    else line_words_reg = data[mbb_pkg::LineW-1:0];
  endtask

  task automatic drain_writes();
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a row that draws nothing finish its scan
  task automatic wait_idle();
    drain_writes();
    repeat (SCAN_CYCLES) @(posedge clk_i);
  endtask

  function automatic row_req_t random_row();
    row_req_t r;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) r.bits = $urandom;
    else if (pick == 6) r.bits = '0;
    else if (pick == 7) r.bits = '1;
    else if (pick == 8) r.bits = 32'h1 << $urandom_range(0, 31);
    else r.bits = $urandom & $urandom & $urandom;
    // mostly narrow rows, some full width, a few zero or oversized
    pick = $urandom_range(0, 19);
    if (pick < 10) r.width = 6'($urandom_range(1, 8));
    else if (pick < 16) r.width = 6'($urandom_range(9, 32));
    else if (pick == 16) r.width = 6'd32;
    else if (pick == 17) r.width = 6'd0;
    else r.width = 6'($urandom_range(33, 63));
    r.sprite_row = 8'($urandom);
    r.org_col = 9'($urandom);
    r.org_row = 8'($urandom);
    r.colour = $urandom;
    r.erase_fg = 1'($urandom_range(0, 1));
    r.erase_bg = 1'($urandom_range(0, 1));
    r.typed_n = PREDICT;
    r.typed_up = '0;
    r.typed_lo = '0;
    r.typed_colour = '0;
    return r;
  endfunction

  // Stream random rows in bursts with random gaps; now and then pause until drained
  task automatic run_phase(input int n);
    int burst;
    int i;
    burst = $urandom_range(1, 24);
    for (i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) begin
          in_valid_i <= 1'b0;
          drain_writes();
        end else if ($urandom_range(0, 3) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      send_row(random_row());
      burst--;
    end
    in_valid_i <= 1'b0;
  endtask

  // Stimulus: reset, directed table, then one random phase per register setting
  initial begin
    int p;
    cfg_set_t s;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_row(dir_tab[i]);
    in_valid_i <= 1'b0;
    wait_idle();

    for (p = 0; p < N_PHASES; p++) begin
      if (p < N_PHASES - 1) begin
        s = cfg_sets[p];
      end else begin
        s.bg = $urandom;
        s.line_words = 13'($urandom_range(0, 8191));
      end
      // upper data bits of the line width write are don't-care; fill them at random
      if ($urandom_range(0, 1)) begin
        cfg_write(mbb_pkg::CfgBgColor, s.bg);
        cfg_write(mbb_pkg::CfgLineWidth, {19'($urandom), s.line_words});
      end else begin
        cfg_write(mbb_pkg::CfgLineWidth, {19'($urandom), s.line_words});
        cfg_write(mbb_pkg::CfgBgColor, s.bg);
      end
      cfg_valid_i <= 1'b0;
      // hold the output off for a long stretch while rows keep coming
      if (p == 1) long_hold_req = 1'b1;
      run_phase(ROWS_PER_PHASE);
      wait_idle();
    end

    if (mismatch_cnt == 0 && pending_writes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: switch between stall patterns, with one long hold-off on request
  initial begin
    rx_mode_e mode;
    int left_in_mode;
    int hold_left;
    int tick;
    mode = RX_FREE;
    left_in_mode = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (left_in_mode == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left_in_mode = $urandom_range(20, 150);
        end
        left_in_mode--;
        case (mode)
          RX_FREE: out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= (tick % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare every accepted write with the oldest one still owed
  always @(posedge clk_i) begin
    pixel_wr_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: pixel_address %h pixel_color %h last_write %b",
               pixel_address_o, pixel_color_o, last_write_o);
        mismatch_cnt++;
      end else begin
        want = pending_writes.pop_front();
        if (pixel_address_o !== want.addr) begin
          $error("pixel_address: expected %h, got %h", want.addr, pixel_address_o);
          mismatch_cnt++;
        end
        if (pixel_color_o !== want.colour) begin
          $error("pixel_color: expected %h, got %h", want.colour, pixel_color_o);
          mismatch_cnt++;
        end
        if (last_write_o !== want.last) begin
          $error("last_write: expected %b, got %b", want.last, last_write_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
